>>> rtl/core/ltfs_pkg.sv
// shared types, codes and default sizes for the led twinkle fade sequencer
// used by the controller, the datapath and the top level; no dependencies
package ltfs_pkg;

	localparam int LTFS_CHANNELS     = 48;
	localparam int LTFS_ACTIVE_SLOTS = 16;
	localparam int LTFS_TABLE_DEPTH  = 256;
	localparam int LTFS_TABLE_COUNT  = 3;

	localparam logic [15:0] LTFS_BLANK = 16'h0000;

	localparam logic [7:0] LTFS_TABLE0_LEN_RST = 8'd60;
	localparam logic [7:0] LTFS_TABLE1_LEN_RST = 8'd90;
	localparam logic [7:0] LTFS_TABLE2_LEN_RST = 8'd120;

	typedef enum logic [1:0] {
		MODE_LOAD  = 2'd0,
		MODE_SETUP = 2'd1,
		MODE_STEP  = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REG_TABLE0_LENGTH = 2'd0,
		REG_TABLE1_LENGTH = 2'd1,
		REG_TABLE2_LENGTH = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_READY   = 3'd0,
		ST_DELAY   = 3'd1,
		ST_FADEIN  = 3'd2,
		ST_HOLD    = 3'd3,
		ST_FADEOUT = 3'd4,
		ST_DONE    = 3'd5
	} stage_t;

	typedef struct packed {
		stage_t      stage;
		logic [7:0]  delay;
		logic [6:0]  hold;
		logic [1:0]  in_sel;
		logic [1:0]  out_sel;
		logic [7:0]  level;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	typedef struct packed {
		logic cap;
		logic rrec;
		logic exec;
		logic load;
	} cmd_t;

	typedef struct packed {
		mode_t mode;
	} stat_t;

endpackage

>>> rtl/core/ltfs_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module ltfs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/core/ltfs_ctrl.sv
// controller state machine: input and output handshakes, datapath commands
// depends on ltfs_pkg
module ltfs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output ltfs_pkg::cmd_t cmd,
	input  ltfs_pkg::stat_t stat
);
	import ltfs_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RREC,
		S_EXEC,
		S_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	assign cmd.cap  = (state_q == S_IDLE) && in_valid;
	assign cmd.rrec = (state_q == S_RREC);
	assign cmd.exec = (state_q == S_EXEC);
	assign cmd.load = (state_q == S_DONE) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_RREC;
					end
				end
				S_RREC: begin
					state_q <= (stat.mode == MODE_STEP) ? S_EXEC : S_DONE;
				end
				S_EXEC: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_accept_to_read: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_RREC)
		else $error("accepted transaction did not start a record read");

	a_exec_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EXEC |-> $past(state_q) == S_RREC)
		else $error("update step without preceding record read");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && !out_valid_q |=> out_valid_q && state_q == S_IDLE)
		else $error("finished result not placed in output register");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q)
		else $error("pending result dropped before its transaction");

endmodule

>>> rtl/core/ltfs_datapath.sv
// datapath: channel record and fade table memories, slot and pool maps,
// stage update logic, length registers and output payload; uses ltfs_pkg, ltfs_ram
module ltfs_datapath #(
	parameter int CHANNELS     = ltfs_pkg::LTFS_CHANNELS,
	parameter int ACTIVE_SLOTS = ltfs_pkg::LTFS_ACTIVE_SLOTS,
	parameter int TABLE_DEPTH  = ltfs_pkg::LTFS_TABLE_DEPTH,
	parameter int TABLE_COUNT  = ltfs_pkg::LTFS_TABLE_COUNT
) (
	input  logic            clk,
	input  logic            arst_n,
	input  ltfs_pkg::cmd_t  cmd,
	output ltfs_pkg::stat_t stat,
	input  logic [1:0]      mode,
	input  logic [1:0]      table_sel,
	input  logic [7:0]      table_pos,
	input  logic [15:0]     table_value,
	input  logic [5:0]      channel,
	input  logic [7:0]      start_delay,
	input  logic [6:0]      hold_ticks,
	input  logic [1:0]      in_select,
	input  logic [1:0]      out_select,
	input  logic [4:0]      pool_pick,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_index,
	input  logic [7:0]      cfg_data,
	output logic [5:0]      out_channel,
	output logic [15:0]     brightness,
	output logic            written,
	output logic            tick_end
);
	import ltfs_pkg::*;

	localparam int POOL_SIZE = CHANNELS - ACTIVE_SLOTS;
	localparam int CH_W      = $clog2(CHANNELS);
	localparam int SL_W      = (ACTIVE_SLOTS > 1) ? $clog2(ACTIVE_SLOTS) : 1;
	localparam int PL_W      = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
	localparam int TP_W      = $clog2(TABLE_DEPTH);
	localparam int TA_DEPTH  = TABLE_COUNT * TABLE_DEPTH;
	localparam int TA_W      = $clog2(TA_DEPTH);
	localparam int SEL_TOP   = (TABLE_COUNT - 1 < 2) ? (TABLE_COUNT - 1) : 2;

	// input transaction latch
	mode_t       mode_q;
	logic [1:0]  tsel_q;
	logic [7:0]  tpos_q;
	logic [15:0] tval_q;
	logic [5:0]  chan_q;
	logic [7:0]  sdel_q;
	logic [6:0]  hold_q;
	logic [1:0]  isel_q;
	logic [1:0]  osel_q;
	logic [4:0]  pick_q;

	// control and map state
	logic [SL_W-1:0] slot_q;
	logic [CH_W-1:0] active_q [ACTIVE_SLOTS];
	logic [CH_W-1:0] pool_q [POOL_SIZE];
	logic            rec_vld_q [CHANNELS];
	logic [7:0]      tlen_q [3];
	logic [CH_W-1:0] ch_q;
	logic            rec_vld_s2;

	// result staging
	logic [CH_W-1:0] res_ch_q;
	logic            res_tab_q;
	logic            res_wr_q;
	logic            res_end_q;

	// constant remainder tables
	logic [TP_W-1:0] pos_mod [256];
	logic [PL_W-1:0] pick_mod [32];

	for (genvar i = 0; i < 256; i++) begin : g_pos_mod
		localparam int PM = i % TABLE_DEPTH;
		assign pos_mod[i] = TP_W'(PM);
	end

	for (genvar i = 0; i < 32; i++) begin : g_pick_mod
		localparam int QM = i % POOL_SIZE;
		assign pick_mod[i] = PL_W'(QM);
	end

	assign stat.mode = mode_q;

	// memories
	logic             rec_we;
	logic [CH_W-1:0]  rec_waddr;
	rec_t             rec_wdata;
	logic [REC_W-1:0] rec_rdata;
	logic             tab_we;
	logic [TA_W-1:0]  tab_waddr;
	logic             tab_re;
	logic [TA_W-1:0]  tab_raddr;
	logic [15:0]      tab_rdata;

	ltfs_ram #(.WIDTH(REC_W), .DEPTH(CHANNELS), .AW(CH_W)) u_rec_ram (
		.clk  (clk),
		.we   (rec_we),
		.waddr(rec_waddr),
		.wdata(rec_wdata),
		.re   (cmd.rrec),
		.raddr(ch_q),
		.rdata(rec_rdata)
	);

	ltfs_ram #(.WIDTH(16), .DEPTH(TA_DEPTH), .AW(TA_W)) u_tab_ram (
		.clk  (clk),
		.we   (tab_we),
		.waddr(tab_waddr),
		.wdata(tval_q),
		.re   (tab_re),
		.raddr(tab_raddr),
		.rdata(tab_rdata)
	);

	// table loads and channel set-up
	logic setup_ok;
	logic load_ok;
	rec_t rec_load;

	assign load_ok  = (32'(tsel_q) < 32'(TABLE_COUNT)) && (32'(tpos_q) < 32'(TABLE_DEPTH));
	assign setup_ok = 32'(chan_q) < 32'(CHANNELS);
	assign tab_we   = cmd.rrec && (mode_q == MODE_LOAD) && load_ok;
	assign tab_waddr = TA_W'(32'(tsel_q) * TABLE_DEPTH + 32'(tpos_q));

	always_comb begin
		rec_load.stage   = ST_READY;
		rec_load.delay   = sdel_q;
		rec_load.hold    = hold_q;
		rec_load.in_sel  = isel_q;
		rec_load.out_sel = osel_q;
		rec_load.level   = '0;
	end

	// stage update
	rec_t       rec_cur;
	rec_t       rec_nxt;
	logic [1:0] in_cl;
	logic [1:0] out_cl;
	logic [1:0] rd_sel;
	logic [7:0] len_in;
	logic [7:0] len_out;
	logic       need_tab;
	logic       wr_nxt;
	logic       swap;
	logic       last_slot;

	assign rec_cur = rec_vld_s2 ? rec_t'(rec_rdata) : rec_t'('0);
	assign in_cl   = (rec_cur.in_sel > 2'(SEL_TOP)) ? 2'(SEL_TOP) : rec_cur.in_sel;
	assign out_cl  = (rec_cur.out_sel > 2'(SEL_TOP)) ? 2'(SEL_TOP) : rec_cur.out_sel;
	assign len_in  = tlen_q[in_cl];
	assign len_out = tlen_q[out_cl];
	assign last_slot = (slot_q == SL_W'(ACTIVE_SLOTS - 1));

	always_comb begin
		rec_nxt  = rec_cur;
		need_tab = 1'b0;
		wr_nxt   = 1'b0;
		swap     = 1'b0;
		rd_sel   = in_cl;
		case (rec_cur.stage)
			ST_READY: begin
				rec_nxt.stage = ST_DELAY;
			end
			ST_DELAY: begin
				if (rec_cur.delay == '0) begin
					rec_nxt.stage = ST_FADEIN;
				end else begin
					rec_nxt.delay = rec_cur.delay - 8'd1;
				end
			end
			ST_FADEIN: begin
				if (rec_cur.level >= len_in) begin
					rec_nxt.stage = ST_HOLD;
				end else begin
					need_tab      = 1'b1;
					wr_nxt        = 1'b1;
					rec_nxt.level = rec_cur.level + 8'd1;
				end
			end
			ST_HOLD: begin
				if (rec_cur.hold == '0) begin
					rec_nxt.level = (len_out != '0) ? len_out - 8'd1 : 8'd0;
					rec_nxt.stage = ST_FADEOUT;
				end else begin
					rec_nxt.hold = rec_cur.hold - 7'd1;
				end
			end
			ST_FADEOUT: begin
				rd_sel = out_cl;
				wr_nxt = 1'b1;
				if (rec_cur.level == '0) begin
					rec_nxt.stage = ST_DONE;
				end else begin
					need_tab      = 1'b1;
					rec_nxt.level = rec_cur.level - 8'd1;
				end
			end
			default: begin
				swap    = 1'b1;
				wr_nxt  = 1'b1;
				rec_nxt = rec_load;
			end
		endcase
	end

	assign tab_re    = cmd.exec && need_tab;
	assign tab_raddr = TA_W'(32'(rd_sel) * TABLE_DEPTH + 32'(pos_mod[rec_cur.level]));

	assign rec_we    = cmd.exec || (cmd.rrec && (mode_q == MODE_SETUP) && setup_ok);
	assign rec_waddr = cmd.exec ? ch_q : CH_W'(chan_q);
	assign rec_wdata = cmd.exec ? rec_nxt : rec_load;

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			mode_q <= mode_t'(mode);
			tsel_q <= table_sel;
			tpos_q <= table_pos;
			tval_q <= table_value;
			chan_q <= channel;
			sdel_q <= start_delay;
			hold_q <= hold_ticks;
			isel_q <= in_select;
			osel_q <= out_select;
			pick_q <= pool_pick;
			ch_q   <= active_q[slot_q];
		end
		if (cmd.rrec) begin
			rec_vld_s2 <= rec_vld_q[ch_q];
		end
		if (cmd.load) begin
			out_channel <= 6'(res_ch_q);
			brightness  <= res_tab_q ? tab_rdata : LTFS_BLANK;
			written     <= res_wr_q;
			tick_end    <= res_end_q;
		end
	end

	// control and map state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q    <= '0;
			res_ch_q  <= '0;
			res_tab_q <= 1'b0;
			res_wr_q  <= 1'b0;
			res_end_q <= 1'b0;
			tlen_q[0] <= LTFS_TABLE0_LEN_RST;
			tlen_q[1] <= LTFS_TABLE1_LEN_RST;
			tlen_q[2] <= LTFS_TABLE2_LEN_RST;
			for (int i = 0; i < ACTIVE_SLOTS; i++) begin
				active_q[i] <= CH_W'(i);
			end
			for (int j = 0; j < POOL_SIZE; j++) begin
				pool_q[j] <= CH_W'(ACTIVE_SLOTS + j);
			end
			for (int k = 0; k < CHANNELS; k++) begin
				rec_vld_q[k] <= 1'b0;
			end
		end else begin
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_index))
					REG_TABLE0_LENGTH: tlen_q[0] <= cfg_data;
					REG_TABLE1_LENGTH: tlen_q[1] <= cfg_data;
					REG_TABLE2_LENGTH: tlen_q[2] <= cfg_data;
					default: ;
				endcase
			end
			if (rec_we) begin
				rec_vld_q[rec_waddr] <= 1'b1;
			end
			if (cmd.cap) begin
				res_ch_q  <= '0;
				res_tab_q <= 1'b0;
				res_wr_q  <= 1'b0;
				res_end_q <= 1'b0;
			end
			if (cmd.exec) begin
				res_ch_q  <= ch_q;
				res_tab_q <= need_tab;
				res_wr_q  <= wr_nxt;
				res_end_q <= last_slot;
				slot_q    <= last_slot ? '0 : slot_q + SL_W'(1);
				if (swap) begin
					active_q[slot_q]        <= pool_q[pick_mod[pick_q]];
					pool_q[pick_mod[pick_q]] <= ch_q;
				end
			end
		end
	end

endmodule

>>> rtl/core/led_twinkle_fade_sequencer.sv
// led twinkle fade sequencer: a step transaction reads the channel record, then
// updates and writes it back while reading the fade table, then loads the result
// register; load and set-up transactions go from the record read straight to the
// result load, which waits for a free output register and precedes any new input.
// reset: stages ready via per-channel valid flags, slot and pool maps restored,
// lengths 60/90/120, no clearing pass; fade tables hold nothing until loaded
module led_twinkle_fade_sequencer #(
	parameter int CHANNELS     = ltfs_pkg::LTFS_CHANNELS,
	parameter int ACTIVE_SLOTS = ltfs_pkg::LTFS_ACTIVE_SLOTS,
	parameter int TABLE_DEPTH  = ltfs_pkg::LTFS_TABLE_DEPTH,
	parameter int TABLE_COUNT  = ltfs_pkg::LTFS_TABLE_COUNT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [1:0]  table_sel,
	input  logic [7:0]  table_pos,
	input  logic [15:0] table_value,
	input  logic [5:0]  channel,
	input  logic [7:0]  start_delay,
	input  logic [6:0]  hold_ticks,
	input  logic [1:0]  in_select,
	input  logic [1:0]  out_select,
	input  logic [4:0]  pool_pick,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  out_channel,
	output logic [15:0] brightness,
	output logic        written,
	output logic        tick_end,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import ltfs_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	ltfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	ltfs_datapath #(
		.CHANNELS    (CHANNELS),
		.ACTIVE_SLOTS(ACTIVE_SLOTS),
		.TABLE_DEPTH (TABLE_DEPTH),
		.TABLE_COUNT (TABLE_COUNT)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.mode       (mode),
		.table_sel  (table_sel),
		.table_pos  (table_pos),
		.table_value(table_value),
		.channel    (channel),
		.start_delay(start_delay),
		.hold_ticks (hold_ticks),
		.in_select  (in_select),
		.out_select (out_select),
		.pool_pick  (pool_pick),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_channel(out_channel),
		.brightness (brightness),
		.written    (written),
		.tick_end   (tick_end)
	);

endmodule

>>> tb/sv/led_twinkle_fade_sequencer_tb.sv
// self-checking testbench for the led twinkle fade sequencer: directed table, table preload,
// then random phases under several length settings and idle mixes, checked by a predictor
// depends on ltfs_pkg and led_twinkle_fade_sequencer
module led_twinkle_fade_sequencer_tb;
	import ltfs_pkg::*;

	localparam int POOL_SIZE = LTFS_CHANNELS - LTFS_ACTIVE_SLOTS;
	localparam logic [1:0] TOP_TABLE =
		2'((LTFS_TABLE_COUNT - 1 < 2) ? LTFS_TABLE_COUNT - 1 : 2);
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int PHASES = 5;

	typedef struct {
		mode_t       mode;
		logic [1:0]  tsel;
		logic [7:0]  tpos;
		logic [15:0] tval;
		logic [5:0]  chan;
		logic [7:0]  delay;
		logic [6:0]  hold;
		logic [1:0]  isel;
		logic [1:0]  osel;
		logic [4:0]  pick;
	} twinkle_cmd_t;

	typedef struct packed {
		logic [5:0]  chan;
		logic [15:0] bright;
		logic        wr;
		logic        last;
	} led_write_t;

	typedef struct {
		twinkle_cmd_t cmd;
		bit           known;
		led_write_t   want;
	} stim_row_t;

	localparam led_write_t NO_WRITE = '0;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  mode = '0;
	logic [1:0]  table_sel = '0;
	logic [7:0]  table_pos = '0;
	logic [15:0] table_value = '0;
	logic [5:0]  channel = '0;
	logic [7:0]  start_delay = '0;
	logic [6:0]  hold_ticks = '0;
	logic [1:0]  in_select = '0;
	logic [1:0]  out_select = '0;
	logic [4:0]  pool_pick = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [5:0]  out_channel;
	logic [15:0] brightness;
	logic        written;
	logic        tick_end;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;

	// predictor state
	rec_t        chan_state [LTFS_CHANNELS];
	logic [5:0]  slot_chan [LTFS_ACTIVE_SLOTS];
	logic [5:0]  spare_chan [POOL_SIZE];
	logic [15:0] fade_mem [LTFS_TABLE_COUNT][LTFS_TABLE_DEPTH];
	logic [7:0]  fade_len [3];
	int          slot_ptr;

	led_write_t  pending_writes [$];
	stim_row_t   directed_rows [$];
	int          fails = 0;
	int          items_sent = 0;
	int          writes_seen = 0;
	int          swaps = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;

	int phase_len [PHASES * 3] = '{2, 0, 3, 255, 1, 4, 3, 2, 0, 1, 40, 2, 4, 5, 6};
	int phase_send [PHASES] = '{0, 54, 0, 21, 0};
	int phase_stall [PHASES] = '{0, 0, 54, 21, 0};
	int phase_items [PHASES] = '{130, 110, 110, 110, 114};

	led_twinkle_fade_sequencer u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.table_sel   (table_sel),
		.table_pos   (table_pos),
		.table_value (table_value),
		.channel     (channel),
		.start_delay (start_delay),
		.hold_ticks  (hold_ticks),
		.in_select   (in_select),
		.out_select  (out_select),
		.pool_pick   (pool_pick),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_channel (out_channel),
		.brightness  (brightness),
		.written     (written),
		.tick_end    (tick_end),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic twinkle_cmd_t make_cmd(mode_t m, logic [1:0] ts, logic [7:0] tp,
			logic [15:0] tv, logic [5:0] ch, logic [7:0] dl, logic [6:0] hd,
			logic [1:0] is, logic [1:0] os, logic [4:0] pk);
		twinkle_cmd_t c;
		c.mode = m;
		c.tsel = ts;
		c.tpos = tp;
		c.tval = tv;
		c.chan = ch;
		c.delay = dl;
		c.hold = hd;
		c.isel = is;
		c.osel = os;
		c.pick = pk;
		return c;
	endfunction

	function automatic twinkle_cmd_t random_cmd();
		int r;
		mode_t m;
		logic [7:0] dl;
		logic [6:0] hd;
		r = $urandom_range(99);
		m = MODE_STEP;
		if (r < 8)
			m = MODE_LOAD;
		else if (r < 18)
			m = MODE_SETUP;
		else if (r < 21)
			m = MODE_NONE;
		// mostly short counts so slots run through to termination
		dl = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(3));
		hd = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(3));
		return make_cmd(m, 2'($urandom_range(3)), 8'($urandom), 16'($urandom),
			6'($urandom_range(63)), dl, hd, 2'($urandom_range(3)), 2'($urandom_range(3)),
			5'($urandom_range(31)));
	endfunction

	function automatic void add_row(twinkle_cmd_t c, bit known, led_write_t want);
		stim_row_t r;
		r.cmd = c;
		r.known = known;
		r.want = want;
		directed_rows.push_back(r);
	endfunction

	function automatic logic [1:0] clamp_table(logic [1:0] s);
		return (s > TOP_TABLE) ? TOP_TABLE : s;
	endfunction

	function automatic void reload_channel(int ch, twinkle_cmd_t c);
		chan_state[ch].stage = ST_READY;
		chan_state[ch].delay = c.delay;
		chan_state[ch].hold = c.hold;
		chan_state[ch].in_sel = c.isel;
		chan_state[ch].out_sel = c.osel;
		chan_state[ch].level = '0;
	endfunction

	function automatic led_write_t sequence_step(twinkle_cmd_t c);
		led_write_t w;
		int slot;
		int ch;
		int pk;
		logic [7:0] len;
		w = NO_WRITE;
		case (c.mode)
			MODE_LOAD: begin
				if (c.tsel < LTFS_TABLE_COUNT && c.tpos < LTFS_TABLE_DEPTH)
					fade_mem[c.tsel][c.tpos] = c.tval;
			end
			MODE_SETUP: begin
				if (c.chan < LTFS_CHANNELS)
					reload_channel(c.chan, c);
			end
			MODE_STEP: begin
				slot = slot_ptr;
				ch = slot_chan[slot];
				w.chan = 6'(ch);
				w.last = (slot == LTFS_ACTIVE_SLOTS - 1);
				slot_ptr = (slot + 1) % LTFS_ACTIVE_SLOTS;
				case (chan_state[ch].stage)
					ST_READY: chan_state[ch].stage = ST_DELAY;
					ST_DELAY: begin
						if (chan_state[ch].delay == 0)
							chan_state[ch].stage = ST_FADEIN;
						else
							chan_state[ch].delay = chan_state[ch].delay - 8'd1;
					end
					ST_FADEIN: begin
						len = fade_len[clamp_table(chan_state[ch].in_sel)];
						if (chan_state[ch].level >= len) begin
							chan_state[ch].stage = ST_HOLD;
						end else begin
							w.bright = fade_mem[clamp_table(chan_state[ch].in_sel)]
								[chan_state[ch].level];
							w.wr = 1'b1;
							chan_state[ch].level = chan_state[ch].level + 8'd1;
						end
					end
					ST_HOLD: begin
						if (chan_state[ch].hold == 0) begin
							len = fade_len[clamp_table(chan_state[ch].out_sel)];
							chan_state[ch].level = (len != 0) ? len - 8'd1 : 8'd0;
							chan_state[ch].stage = ST_FADEOUT;
						end else begin
							chan_state[ch].hold = chan_state[ch].hold - 7'd1;
						end
					end
					ST_FADEOUT: begin
						w.wr = 1'b1;
						if (chan_state[ch].level == 0) begin
							w.bright = LTFS_BLANK;
							chan_state[ch].stage = ST_DONE;
						end else begin
							w.bright = fade_mem[clamp_table(chan_state[ch].out_sel)]
								[chan_state[ch].level];
							chan_state[ch].level = chan_state[ch].level - 8'd1;
						end
					end
					default: begin
						// terminated: swap with a pool entry and refresh the old channel
						pk = c.pick % POOL_SIZE;
						slot_chan[slot] = spare_chan[pk];
						spare_chan[pk] = 6'(ch);
						reload_channel(ch, c);
						w.bright = LTFS_BLANK;
						w.wr = 1'b1;
						swaps++;
					end
				endcase
			end
			default: ;
		endcase
		return w;
	endfunction

	task automatic push_item(twinkle_cmd_t c, bit known, led_write_t want);
		int gap;
		led_write_t w;
		gap = 0;
		while (gap < 30 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= c.mode;
		table_sel <= c.tsel;
		table_pos <= c.tpos;
		table_value <= c.tval;
		channel <= c.chan;
		start_delay <= c.delay;
		hold_ticks <= c.hold;
		in_select <= c.isel;
		out_select <= c.osel;
		pool_pick <= c.pick;
		do @(posedge clk); while (!in_ready);
		w = sequence_step(c);
		pending_writes.push_back(known ? want : w);
		items_sent++;
	endtask

	task automatic wait_all_written();
		in_valid <= 1'b0;
		while (pending_writes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_length(logic [1:0] idx, logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx <= REG_TABLE2_LENGTH)
			fade_len[idx] = val;
	endtask

	task automatic check_field(string what, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
			fails++;
		end
	endtask

	always @(posedge clk) begin : result_check
		led_write_t want;
		if (arst_n && out_valid && out_ready) begin
			if (written === 1'b1)
				writes_seen++;
			if (pending_writes.size() == 0) begin
				$display("%0t: unexpected transaction, expected none, actual ch %0d br %0h",
					$time, out_channel, brightness);
				fails++;
			end else begin
				want = pending_writes.pop_front();
				check_field("out_channel", want.chan, out_channel);
				check_field("brightness", want.bright, brightness);
				check_field("written", want.wr, written);
				check_field("tick_end", want.last, tick_end);
			end
		end
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	initial begin
		int i;
		int p;
		int s;
		int need;
		led_write_t w;
		for (i = 0; i < LTFS_CHANNELS; i++)
			chan_state[i] = '0;
		for (i = 0; i < LTFS_ACTIVE_SLOTS; i++)
			slot_chan[i] = 6'(i);
		for (i = 0; i < POOL_SIZE; i++)
			spare_chan[i] = 6'(LTFS_ACTIVE_SLOTS + i);
		slot_ptr = 0;
		fade_len[0] = LTFS_TABLE0_LEN_RST;
		fade_len[1] = LTFS_TABLE1_LEN_RST;
		fade_len[2] = LTFS_TABLE2_LEN_RST;

		// directed rows: loads, set-ups, unused mode, another set-up, then one pass over the slots and one more step
		add_row(make_cmd(MODE_LOAD, 2'd0, 8'd0, 16'h0000, 6'd0, 8'd0, 7'd0, 2'd0, 2'd0, 5'd0),
			1'b1, NO_WRITE);
		add_row(make_cmd(MODE_LOAD, 2'd2, 8'd255, 16'hFFFF, 6'd63, 8'd255, 7'd127, 2'd3, 2'd3,
			5'd31), 1'b1, NO_WRITE);
		add_row(make_cmd(MODE_LOAD, 2'd3, 8'd128, 16'h5A5A, 6'd5, 8'd1, 7'd1, 2'd1, 2'd1, 5'd1),
			1'b1, NO_WRITE);
		add_row(make_cmd(MODE_SETUP, 2'd0, 8'd0, 16'h0000, 6'd47, 8'd255, 7'd127, 2'd3, 2'd3,
			5'd0), 1'b1, NO_WRITE);
		add_row(make_cmd(MODE_SETUP, 2'd0, 8'd0, 16'h0000, 6'd48, 8'd7, 7'd7, 2'd1, 2'd2, 5'd0),
			1'b1, NO_WRITE);
		add_row(make_cmd(MODE_SETUP, 2'd0, 8'd0, 16'h0000, 6'd63, 8'd9, 7'd9, 2'd2, 2'd1, 5'd0),
			1'b1, NO_WRITE);
		add_row(make_cmd(MODE_NONE, 2'd3, 8'd255, 16'hFFFF, 6'd63, 8'd255, 7'd127, 2'd3, 2'd3,
			5'd31), 1'b1, NO_WRITE);
		add_row(make_cmd(MODE_SETUP, 2'd0, 8'd0, 16'h0000, 6'd0, 8'd0, 7'd0, 2'd0, 2'd0, 5'd0),
			1'b1, NO_WRITE);
		for (i = 0; i < LTFS_ACTIVE_SLOTS; i++) begin
			w = NO_WRITE;
			w.chan = 6'(i);
			w.last = (i == LTFS_ACTIVE_SLOTS - 1);
			add_row(make_cmd(MODE_STEP, 2'(i), 8'(i * 17), 16'(i * 4369), 6'(i), 8'd255, 7'd127,
				2'(i), 2'(i + 1), 5'd31), 1'b1, w);
		end
		add_row(make_cmd(MODE_STEP, 2'd0, 8'd0, 16'h0000, 6'd0, 8'd0, 7'd0, 2'd0, 2'd0, 5'd0),
			1'b0, NO_WRITE);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			push_item(directed_rows[i].cmd, directed_rows[i].known, directed_rows[i].want);

		// fill every table word that a fade can reach under the phase lengths
		for (s = 0; s < LTFS_TABLE_COUNT; s++) begin
			need = 0;
			for (p = 0; p < PHASES; p++)
				if (phase_len[3 * p + s] > need)
					need = phase_len[3 * p + s];
			for (i = 0; i < need; i++)
				push_item(make_cmd(MODE_LOAD, 2'(s), 8'(i), 16'($urandom), 6'($urandom_range(63)),
					8'($urandom), 7'($urandom), 2'($urandom), 2'($urandom), 5'($urandom)),
					1'b0, NO_WRITE);
		end
		wait_all_written();

		for (p = 0; p < PHASES; p++) begin
			write_length(REG_TABLE0_LENGTH, 8'(phase_len[3 * p]));
			write_length(REG_TABLE1_LENGTH, 8'(phase_len[3 * p + 1]));
			write_length(REG_TABLE2_LENGTH, 8'(phase_len[3 * p + 2]));
			if (p == 0)
				write_length(REG_UNUSED, 8'hFF);
			cfg_valid <= 1'b0;
			send_idle_pct = phase_send[p];
			recv_stall_pct = phase_stall[p];
			for (i = 0; i < phase_items[p]; i++) begin
				push_item(random_cmd(), 1'b0, NO_WRITE);
				if (i % 150 == 75)
					wait_all_written();
			end
			wait_all_written();
		end

		$display("run covered %0d transactions over %0d length settings and four idle mixes",
			items_sent, PHASES);
		$display("%0d brightness writes seen, %0d slot swaps through the pool", writes_seen, swaps);
		if (fails == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
